// ===== design/assert_macros.svh =====
// Assertion macros shared by the parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked with the non-overlapping operator |=>
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/socks5_pkg.sv =====
// Types and constants for the SOCKS5 handshake parser
package socks5_pkg;
    localparam logic [7:0] VERSION_5   = 8'h05;
    localparam logic [7:0] ATYP_IPV4   = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN = 8'h03;
    localparam logic [7:0] ATYP_IPV6   = 8'h04;
    localparam logic [7:0] METHOD_NONE = 8'h00;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        PH_IDLE, PH_G_NMETH, PH_G_METH, PH_R_CMD, PH_R_RSV,
        PH_R_ATYP, PH_R_DLEN, PH_R_ADDR, PH_R_PORTH, PH_R_PORTL
    } phase_t;

    typedef enum logic [1:0] {
        RK_ADDR = 2'd0, RK_GREET = 2'd1, RK_REQ = 2'd2, RK_ERR = 2'd3
    } rkind_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       kind;
        logic       ver_ok;
        logic       atyp_known;
        logic [1:0] atyp_code;
        logic       is_zero;
    } cls_item_t;

    typedef struct packed {
        rkind_t      kind;
        logic [7:0]  addr_byte;
        logic [7:0]  addr_index;
        logic        no_auth;
        logic [7:0]  cmd;
        logic [1:0]  atyp;
        logic [15:0] port;
        logic [8:0]  count;
    } result_t;
endpackage

// ===== design/socks5_front.sv =====
// Front: byte classification into a short queue
module socks5_front
    import socks5_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       message_kind,
    output logic       q_valid,
    input  logic       q_ready,
    output cls_item_t  q_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    cls_item_t       mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]     cnt_reg, cnt_next;
    cls_item_t       cls;
    logic            push, pop;

    always_comb
    begin
        cls.data       = data_byte;
        cls.first      = first_byte;
        cls.kind       = message_kind;
        cls.ver_ok     = (data_byte == VERSION_5);
        cls.is_zero    = (data_byte == METHOD_NONE);
        cls.atyp_known = 1'b1;
        cls.atyp_code  = 2'd0;
        case (data_byte)
            ATYP_IPV4:   cls.atyp_code = 2'd0;
            ATYP_DOMAIN: cls.atyp_code = 2'd1;
            ATYP_IPV6:   cls.atyp_code = 2'd2;
            default:     cls.atyp_known = 1'b0;
        endcase
    end

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
            wp_next = (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
        if (pop)
            rp_next = (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= cls;
    end
endmodule

// ===== design/socks5_back.sv =====
// Back: parse state machine and output register
module socks5_back
    import socks5_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  cls_item_t q_item,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   res
);
    phase_t      phase_reg, phase_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [7:0]  meth_reg, meth_next;
    logic [7:0]  alen_reg, alen_next;
    logic [7:0]  apos_reg, apos_next;
    logic [1:0]  atyp_reg, atyp_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  porth_reg, porth_next;
    logic        na_reg, na_next;
    logic        ov_reg;
    result_t     res_reg, r;
    logic        emit, take;

    // output register frees as it is read, so an item flows every cycle unless a held result waits on out_ready
    assign q_ready   = !ov_reg || out_ready;
    assign take      = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign res       = res_reg;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        meth_next  = meth_reg;
        alen_next  = alen_reg;
        apos_next  = apos_reg;
        atyp_next  = atyp_reg;
        cmd_next   = cmd_reg;
        porth_next = porth_reg;
        na_next    = na_reg;
        if (q_item.first)
        begin
            cnt_next   = 9'd1;
            meth_next  = '0;
            alen_next  = '0;
            apos_next  = '0;
            atyp_next  = '0;
            cmd_next   = '0;
            porth_next = '0;
            na_next    = 1'b0;
            if (!q_item.ver_ok)
                phase_next = PH_IDLE;
            else
                phase_next = q_item.kind ? PH_R_CMD : PH_G_NMETH;
        end
        else if (phase_reg != PH_IDLE)
        begin
            cnt_next = cnt_reg + 9'd1;
            case (phase_reg)
                PH_G_NMETH:
                begin
                    meth_next  = q_item.data;
                    phase_next = q_item.is_zero ? PH_IDLE : PH_G_METH;
                end
                PH_G_METH:
                begin
                    if (q_item.is_zero)
                        na_next = 1'b1;
                    meth_next = meth_reg - 8'd1;
                    if (meth_reg == 8'd1)
                        phase_next = PH_IDLE;
                end
                PH_R_CMD:
                begin
                    cmd_next   = q_item.data;
                    phase_next = PH_R_RSV;
                end
                PH_R_RSV:
                    phase_next = PH_R_ATYP;
                PH_R_ATYP:
                begin
                    apos_next = '0;
                    if (!q_item.atyp_known)
                        phase_next = PH_IDLE;
                    else
                    begin
                        atyp_next = q_item.atyp_code;
                        case (q_item.atyp_code)
                            2'd0:
                            begin
                                alen_next  = 8'd4;
                                phase_next = PH_R_ADDR;
                            end
                            2'd2:
                            begin
                                alen_next  = 8'd16;
                                phase_next = PH_R_ADDR;
                            end
                            default:
                                phase_next = PH_R_DLEN;
                        endcase
                    end
                end
                PH_R_DLEN:
                begin
                    alen_next  = q_item.data;
                    phase_next = q_item.is_zero ? PH_R_PORTH : PH_R_ADDR;
                end
                PH_R_ADDR:
                begin
                    apos_next = apos_reg + 8'd1;
                    if (apos_next == alen_reg)
                        phase_next = PH_R_PORTH;
                end
                PH_R_PORTH:
                begin
                    porth_next = q_item.data;
                    phase_next = PH_R_PORTL;
                end
                PH_R_PORTL:
                    phase_next = PH_IDLE;
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        emit = 1'b0;
        r    = '0;
        if (q_item.first)
        begin
            if (!q_item.ver_ok)
            begin
                emit   = 1'b1;
                r.kind = RK_ERR;
            end
        end
        else
        begin
            case (phase_reg)
                PH_G_NMETH, PH_G_METH:
                begin
                    if ((phase_reg == PH_G_NMETH && q_item.is_zero) ||
                        (phase_reg == PH_G_METH && meth_reg == 8'd1))
                    begin
                        emit      = 1'b1;
                        r.kind    = RK_GREET;
                        r.no_auth = na_next;
                        r.count   = cnt_next;
                    end
                end
                PH_R_ATYP:
                begin
                    if (!q_item.atyp_known)
                    begin
                        emit   = 1'b1;
                        r.kind = RK_ERR;
                    end
                end
                PH_R_ADDR:
                begin
                    emit         = 1'b1;
                    r.kind       = RK_ADDR;
                    r.addr_byte  = q_item.data;
                    r.addr_index = apos_reg;
                end
                PH_R_PORTL:
                begin
                    emit   = 1'b1;
                    r.kind = RK_REQ;
                    r.cmd  = cmd_reg;
                    r.atyp = atyp_reg;
                    r.port = {porth_reg, q_item.data};
                    r.count = cnt_next;
                end
                default:
                    emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            meth_reg  <= '0;
            alen_reg  <= '0;
            apos_reg  <= '0;
            atyp_reg  <= '0;
            cmd_reg   <= '0;
            porth_reg <= '0;
            na_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                meth_reg  <= meth_next;
                alen_reg  <= alen_next;
                apos_reg  <= apos_next;
                atyp_reg  <= atyp_next;
                cmd_reg   <= cmd_next;
                porth_reg <= porth_next;
                na_reg    <= na_next;
            end
            if (take)
                ov_reg <= emit;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
            res_reg <= r;
    end
endmodule

// ===== design/socks5_handshake_parser.sv =====
// Top level of the SOCKS5 handshake parser
//
//  channel | direction | signals
//  in      | input     | in_valid/in_ready, data_byte, first_byte, message_kind
//  out     | output    | out_valid/out_ready, result_kind .. bytes_consumed
//
// One byte per cycle sustained while out is not stalled; a byte passes through the
// classify queue and then the output register.
// Reset empties the queue, returns the parse state to idle and clears out_valid.
// The queue lets input keep flowing for up to DEPTH bytes while out stalls.
module socks5_handshake_parser
    import socks5_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        message_kind,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  address_byte,
    output logic [7:0]  address_index,
    output logic        no_auth_offered,
    output logic [7:0]  command_code,
    output logic [1:0]  address_type,
    output logic [15:0] dest_port,
    output logic [8:0]  bytes_consumed
);
`include "assert_macros.svh"

    logic      q_valid, q_ready;
    cls_item_t q_item;
    result_t   res;

    socks5_front #(.DEPTH(DEPTH)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .data_byte, .first_byte,
        .message_kind, .q_valid, .q_ready, .q_item
    );

    socks5_back u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_item, .out_valid, .out_ready, .res
    );

    assign result_kind     = res.kind;
    assign address_byte    = res.addr_byte;
    assign address_index   = res.addr_index;
    assign no_auth_offered = res.no_auth;
    assign command_code    = res.cmd;
    assign address_type    = res.atyp;
    assign dest_port       = res.port;
    assign bytes_consumed  = res.count;

    `ASSERT_CLK(a_atyp_range, !out_valid || address_type != 2'd3, "bad address type")
    `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(res),
        "result changed while stalled")
    `ASSERT_CLK(a_err_clean, !out_valid || result_kind != RK_ERR || bytes_consumed == '0,
        "error result carries a count")
endmodule

// ===== sim/tb.sv =====
// Testbench for the SOCKS5 handshake parser: queued byte driver, scoreboard monitor
module tb;
    import socks5_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        message_kind;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [7:0]  address_byte;
    logic [7:0]  address_index;
    logic        no_auth_offered;
    logic [7:0]  command_code;
    logic [1:0]  address_type;
    logic [15:0] dest_port;
    logic [8:0]  bytes_consumed;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       kind;
        logic       hold;   // pause before this item until all results are in
    } byte_item_t;

    byte_item_t byte_q[$];
    result_t    expected_q[$];
    int         errors;
    int         cycles;
    bit         stim_done;
    bit         calm;

    // parser model state
    phase_t     ph;
    logic [8:0] cnt;
    logic [7:0] meth_left;
    logic [7:0] addr_len;
    logic [7:0] addr_pos;
    logic [1:0] atyp_r;
    logic [7:0] cmd_r;
    logic [7:0] port_hi;
    logic       noauth_r;

    socks5_handshake_parser i_dut (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic result_t blank_result(rkind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    task automatic parse_byte(byte_item_t it);
        result_t r;
        if (it.first)
        begin
            cnt = 1; meth_left = 0; addr_len = 0; addr_pos = 0;
            atyp_r = 0; cmd_r = 0; port_hi = 0; noauth_r = 0;
            if (it.data != VERSION_5)
            begin
                expected_q.push_back(blank_result(RK_ERR));
                ph = PH_IDLE;
            end
            else
                ph = it.kind ? PH_R_CMD : PH_G_NMETH;
            return;
        end
        if (ph == PH_IDLE)
            return;
        cnt = cnt + 9'd1;
        case (ph)
            PH_G_NMETH, PH_G_METH:
            begin
                if (ph == PH_G_NMETH)
                    meth_left = it.data;
                else
                begin
                    if (it.data == METHOD_NONE)
                        noauth_r = 1;
                    meth_left = meth_left - 8'd1;
                end
                ph = PH_G_METH;
                if (meth_left == 0)
                begin
                    r = blank_result(RK_GREET);
                    r.no_auth = noauth_r;
                    r.count = cnt;
                    expected_q.push_back(r);
                    ph = PH_IDLE;
                end
            end
            PH_R_CMD:
            begin
                cmd_r = it.data;
                ph = PH_R_RSV;
            end
            PH_R_RSV: ph = PH_R_ATYP;
            PH_R_ATYP:
            begin
                addr_pos = 0;
                if (it.data == ATYP_IPV4)
                begin
                    atyp_r = 0; addr_len = 4; ph = PH_R_ADDR;
                end
                else if (it.data == ATYP_DOMAIN)
                begin
                    atyp_r = 1; ph = PH_R_DLEN;
                end
                else if (it.data == ATYP_IPV6)
                begin
                    atyp_r = 2; addr_len = 16; ph = PH_R_ADDR;
                end
                else
                begin
                    expected_q.push_back(blank_result(RK_ERR));
                    ph = PH_IDLE;
                end
            end
            PH_R_DLEN:
            begin
                addr_len = it.data;
                ph = (addr_len == 0) ? PH_R_PORTH : PH_R_ADDR;
            end
            PH_R_ADDR:
            begin
                r = blank_result(RK_ADDR);
                r.addr_byte = it.data;
                r.addr_index = addr_pos;
                expected_q.push_back(r);
                addr_pos = addr_pos + 8'd1;
                if (addr_pos == addr_len)
                    ph = PH_R_PORTH;
            end
            PH_R_PORTH:
            begin
                port_hi = it.data;
                ph = PH_R_PORTL;
            end
            PH_R_PORTL:
            begin
                r = blank_result(RK_REQ);
                r.cmd = cmd_r;
                r.atyp = atyp_r;
                r.port = {port_hi, it.data};
                r.count = cnt;
                expected_q.push_back(r);
                ph = PH_IDLE;
            end
            default: ph = PH_IDLE;
        endcase
    endtask

    function automatic void add_byte(logic [7:0] d, logic f = 0, logic k = 0, logic h = 0);
        byte_item_t it;
        it.data = d; it.first = f; it.kind = k; it.hold = h;
        byte_q.push_back(it);
    endfunction

    function automatic void add_greeting(int n, bit with_none);
        add_byte(VERSION_5, 1, 0);
        add_byte(n[7:0]);
        for (int i = 0; i < n; i++)
            add_byte((with_none && i == n - 1) ? METHOD_NONE : 8'($urandom_range(1, 255)));
    endfunction

    // atyp_sel: 0 IPv4, 1 domain, 2 IPv6
    function automatic void add_request(int atyp_sel, int dlen, logic [15:0] port);
        int n;
        add_byte(VERSION_5, 1, 1);
        add_byte(8'($urandom));
        add_byte(8'($urandom));
        case (atyp_sel)
            0: begin add_byte(ATYP_IPV4); n = 4; end
            1: begin add_byte(ATYP_DOMAIN); add_byte(dlen[7:0]); n = dlen; end
            default: begin add_byte(ATYP_IPV6); n = 16; end
        endcase
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom));
        add_byte(port[15:8]);
        add_byte(port[7:0]);
    endfunction

    function automatic void add_random_message();
        int sel;
        int cut;
        int start;
        sel = $urandom_range(0, 99);
        start = byte_q.size();
        if (sel < 40)
            add_greeting($urandom_range(0, 6), 1'($urandom_range(0, 1)));
        else if (sel < 85)
            add_request($urandom_range(0, 2), $urandom_range(0, 12), 16'($urandom));
        else if (sel < 90)
            add_request(1, $urandom_range(200, 255), 16'($urandom));
        else
        begin
            // noise: random first byte, bad versions, stray bytes, bad atyp
            add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (int i = $urandom_range(0, 5); i > 0; i--)
                add_byte(8'($urandom));
        end
        // occasionally truncate so the next first byte restarts mid-message
        if (sel < 85 && $urandom_range(0, 9) == 0)
        begin
            cut = start + $urandom_range(1, byte_q.size() - start);
            while (byte_q.size() > cut)
                void'(byte_q.pop_back());
        end
    endfunction

    // stimulus plan
    initial
    begin
        add_greeting(0, 0);
        add_greeting(1, 1);
        add_greeting(3, 0);
        add_byte(8'h04, 1, 0);
        add_byte(8'hff);
        add_byte(8'h00);
        add_request(0, 0, 16'h0000);
        add_request(2, 0, 16'hffff);
        add_request(1, 0, 16'h1234);
        add_request(1, 255, 16'h0050);
        add_byte(VERSION_5, 1, 1, 1);
        add_byte(8'h01);
        add_byte(8'h00);
        add_byte(8'h02);
        add_byte(8'hff, 1, 1);
        add_byte(VERSION_5, 1, 0);
        add_byte(8'h05);
        add_byte(VERSION_5, 1, 1);
        add_byte(8'h01);
        add_byte(8'h00);
        add_byte(ATYP_IPV4);
        add_byte(8'hab);
        while (byte_q.size() < 830)
            add_random_message();
        byte_q[byte_q.size() / 2].hold = 1;
    end

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 0;
            data_byte    <= 0;
            first_byte   <= 0;
            message_kind <= 0;
            stim_done    <= 0;
        end
        else
        begin
            automatic bit sending = in_valid;
            if (in_valid && in_ready)
                sending = 0;
            if (!sending)
            begin
                if (byte_q.size() == 0)
                begin
                    in_valid  <= 0;
                    stim_done <= 1;
                end
                else if (byte_q[0].hold && (expected_q.size() != 0 || out_valid))
                    in_valid <= 0;
                else if (!calm && $urandom_range(0, 99) < 29)
                    in_valid <= 0;
                else
                begin
                    byte_item_t it;
                    it = byte_q.pop_front();
                    in_valid     <= 1;
                    data_byte    <= it.data;
                    first_byte   <= it.first;
                    message_kind <= it.kind;
                    parse_byte(it);
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 0;
        else
        begin
            if (out_valid && out_ready)
            begin
                result_t got;
                result_t exp;
                got = '{rkind_t'(result_kind), address_byte, address_index, no_auth_offered,
                        command_code, address_type, dest_port, bytes_consumed};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %p", $time, got);
                    errors++;
                end
                else
                begin
                    exp = expected_q.pop_front();
                    if (got.kind != exp.kind)
                    begin
                        $display("%0t: result_kind expected %0d actual %0d", $time, exp.kind, got.kind);
                        errors++;
                    end
                    if (got.addr_byte != exp.addr_byte || got.addr_index != exp.addr_index)
                    begin
                        $display("%0t: address byte/index expected %h/%0d actual %h/%0d", $time,
                                 exp.addr_byte, exp.addr_index, got.addr_byte, got.addr_index);
                        errors++;
                    end
                    if (got.no_auth != exp.no_auth)
                    begin
                        $display("%0t: no_auth_offered expected %b actual %b", $time,
                                 exp.no_auth, got.no_auth);
                        errors++;
                    end
                    if (got.cmd != exp.cmd || got.atyp != exp.atyp)
                    begin
                        $display("%0t: command/atyp expected %h/%0d actual %h/%0d", $time,
                                 exp.cmd, exp.atyp, got.cmd, got.atyp);
                        errors++;
                    end
                    if (got.port != exp.port || got.count != exp.count)
                    begin
                        $display("%0t: port/count expected %h/%0d actual %h/%0d", $time,
                                 exp.port, exp.count, got.port, got.count);
                        errors++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    // stretch without idling on either side, placed while bytes are still queued
    always @(posedge clk)
        calm <= (cycles > 300 && cycles < 800);

    initial
    begin
        int tail;
        errors = 0;
        cycles = 0;
        calm   = 0;
        ph = PH_IDLE; cnt = 0; meth_left = 0; addr_len = 0; addr_pos = 0;
        atyp_r = 0; cmd_r = 0; port_hi = 0; noauth_r = 0;
        rst_n = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        tail = 0;
        while (tail < 20 && cycles < 200000)
        begin
            @(posedge clk);
            cycles++;
            if (stim_done && expected_q.size() == 0)
                tail++;
            else
                tail = 0;
        end
        if (cycles >= 200000)
            $display("simulation failed");
        else if (errors == 0 && expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
